// File: rtl/core/yaz0_pkg.sv
// ----------------------------------------------------------------------------
// yaz0_pkg
// Shared types and constants for the Yaz0 stream decompressor.
// ----------------------------------------------------------------------------
package yaz0_pkg;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

  localparam int OFF_W       = 12;
  localparam int LEN_W       = 9;
  localparam int MAX_RESULTS = 35;
  localparam int RES_CNT_W   = 6;

  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_SKIP_BIG  = 3'd2;
  localparam logic [2:0] ST_SIZE_SAT  = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  localparam logic [3:0] HDR_MAGIC_END = 4'd4;
  localparam logic [3:0] HDR_SIZE_LAST = 4'd7;
  localparam logic [3:0] HDR_LAST      = 4'd15;

  localparam logic [LEN_W-1:0] SHORT_LEN_BIAS = 9'd2;
  localparam logic [LEN_W-1:0] LONG_LEN_BASE  = 9'h012;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_STAT,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             start;
    logic             ld_size;
    logic             stop;
    logic [2:0]       status;
    logic [7:0]       data;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic [31:0]      size;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FLAG,
    PH_ITEM,
    PH_CODE2,
    PH_CODE3
  } phase_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_FLUSH
  } back_state_e;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    unique case (pos)
      2'd0:    m = 8'h59;  // Y
      2'd1:    m = 8'h61;  // a
      2'd2:    m = 8'h7A;  // z
      default: m = 8'h30;  // 0
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/yaz0_front.sv
// ----------------------------------------------------------------------------
// yaz0_front
// Header check and group parser; turns each byte into at most one back-end command.
// ----------------------------------------------------------------------------
module yaz0_front
  import yaz0_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             stream_start_i,
  input  logic [REG_W-1:0] skip_count_i,
  input  logic [REG_W-1:0] emit_limit_i,
  input  logic             clear_done_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  phase_e      phase_q, phase_d, ph_eff, ph_nf;
  logic [3:0]  hpos_q, hpos_d, hpos_eff;
  logic [31:0] size_q, size_d, size_eff, acc_new;
  logic [7:0]  flags_q, flags_d, flags_eff;
  logic [3:0]  left_q, left_d, left_eff, left_nf;
  logic [7:0]  pend_q, pend_d, low_q, low_d;
  logic        accept, magic_bad, skip_big, nothing;

  assign in_ready_o = cmd_ready_i && clear_done_i;
  assign accept     = in_valid_i && in_ready_o;

  // a start beat always reopens the header
  assign ph_eff    = stream_start_i ? PH_HEADER : phase_q;
  assign hpos_eff  = stream_start_i ? 4'd0 : hpos_q;
  assign size_eff  = stream_start_i ? 32'd0 : size_q;
  assign flags_eff = stream_start_i ? 8'd0 : flags_q;
  assign left_eff  = stream_start_i ? 4'd0 : left_q;

  assign acc_new   = {size_eff[23:0], in_byte_i};
  assign magic_bad = (hpos_eff < HDR_MAGIC_END) && (in_byte_i != magic_byte(hpos_eff[1:0]));
  assign skip_big  = 32'(skip_count_i) > size_eff;
  assign nothing   = (size_eff == 32'd0) || (emit_limit_i == '0);
  assign left_nf   = (left_eff != 4'd0) ? left_eff - 4'd1 : 4'd0;
  assign ph_nf     = (left_nf == 4'd0) ? PH_FLAG : PH_ITEM;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (ph_eff)
        PH_HEADER: begin
          if (magic_bad) begin
            phase_d = PH_IDLE;
          end else if (hpos_eff == HDR_LAST) begin
            phase_d = (skip_big || nothing) ? PH_IDLE : PH_FLAG;
          end else begin
            phase_d = PH_HEADER;
          end
        end
        PH_FLAG:  phase_d = PH_ITEM;
        PH_ITEM:  phase_d = flags_eff[7] ? ph_nf : PH_CODE2;
        PH_CODE2: phase_d = (pend_q[7:4] != 4'd0) ? ph_nf : PH_CODE3;
        PH_CODE3: phase_d = ph_nf;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // command and parser registers
  always_comb begin
    hpos_d  = hpos_q;
    size_d  = size_q;
    flags_d = flags_q;
    left_d  = left_q;
    pend_d  = pend_q;
    low_d   = low_q;
    cmd_o         = '0;
    cmd_o.kind    = CMD_NOP;
    cmd_o.start   = stream_start_i;
    cmd_o.status  = ST_DATA;
    cmd_o.data    = in_byte_i;
    cmd_o.off     = {pend_q[3:0], in_byte_i};
    cmd_o.size    = size_eff;
    if (accept && stream_start_i) begin
      hpos_d  = '0;
      size_d  = '0;
      flags_d = '0;
      left_d  = '0;
      pend_d  = '0;
      low_d   = '0;
    end
    unique case (ph_eff)
      PH_HEADER: begin
        hpos_d = hpos_eff + 4'd1;
        if (magic_bad) begin
          cmd_o.kind   = CMD_STAT;
          cmd_o.status = ST_BAD_MAGIC;
          cmd_o.stop   = 1'b1;
        end else if (hpos_eff >= HDR_MAGIC_END && hpos_eff <= HDR_SIZE_LAST) begin
          size_d = acc_new;
          if (hpos_eff == HDR_SIZE_LAST && {1'b0, acc_new} > COUNT_MAX) begin
            size_d       = COUNT_MAX[31:0];
            cmd_o.kind   = CMD_STAT;
            cmd_o.status = ST_SIZE_SAT;
          end
        end else if (hpos_eff == HDR_LAST) begin
          cmd_o.ld_size = 1'b1;
          if (skip_big) begin
            cmd_o.kind   = CMD_STAT;
            cmd_o.status = ST_SKIP_BIG;
            cmd_o.stop   = 1'b1;
          end else if (nothing) begin
            cmd_o.kind   = CMD_STAT;
            cmd_o.status = ST_DONE;
            cmd_o.stop   = 1'b1;
          end
        end
      end
      PH_FLAG: begin
        flags_d = in_byte_i;
        left_d  = 4'd8;
      end
      PH_ITEM: begin
        if (flags_eff[7]) begin
          cmd_o.kind = CMD_LIT;
          flags_d    = {flags_eff[6:0], 1'b0};
          left_d     = left_nf;
        end else begin
          pend_d = in_byte_i;
        end
      end
      PH_CODE2: begin
        low_d = in_byte_i;
        if (pend_q[7:4] != 4'd0) begin
          cmd_o.kind = CMD_COPY;
          cmd_o.len  = LEN_W'(pend_q[7:4]) + SHORT_LEN_BIAS;
          flags_d    = {flags_eff[6:0], 1'b0};
          left_d     = left_nf;
        end
      end
      PH_CODE3: begin
        cmd_o.kind = CMD_COPY;
        cmd_o.off  = {pend_q[3:0], low_q};
        cmd_o.len  = LEN_W'(in_byte_i) + LONG_LEN_BASE;
        flags_d    = {flags_eff[6:0], 1'b0};
        left_d     = left_nf;
      end
      default: ;
    endcase
    if (!accept) begin
      hpos_d  = hpos_q;
      size_d  = size_q;
      flags_d = flags_q;
      left_d  = left_q;
      pend_d  = pend_q;
      low_d   = low_q;
    end
  end

  assign cmd_valid_o = accept && (cmd_o.kind != CMD_NOP || cmd_o.start || cmd_o.ld_size);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hpos_q  <= '0;
      size_q  <= '0;
      flags_q <= '0;
      left_q  <= '0;
      pend_q  <= '0;
      low_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      size_q  <= size_d;
      flags_q <= flags_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      low_q   <= low_d;
    end
  end

endmodule

// File: rtl/core/yaz0_cmd_fifo.sv
// ----------------------------------------------------------------------------
// yaz0_cmd_fifo
// Four-entry command queue between parser and copy engine.
// ----------------------------------------------------------------------------
module yaz0_cmd_fifo
  import yaz0_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 3'd4;
  assign rd_valid_o = cnt_q != 3'd0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 2'd1;
      if (pop)  rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end

endmodule

// File: rtl/core/yaz0_back.sv
// ----------------------------------------------------------------------------
// yaz0_back
// Copy engine: history window, skip/limit counting and lane packing.
// ----------------------------------------------------------------------------
module yaz0_back
  import yaz0_pkg::*;
#(
  parameter int LANE_BYTES   = 8,
  parameter int COUNT_BITS   = 24,
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  input  logic [REG_W-1:0] skip_count_i,
  input  logic [REG_W-1:0] emit_limit_i,
  output logic             clear_done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             run_last_o,
  output logic [2:0]       status_o
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

  back_state_e state_q, state_d;

  logic [7:0]  mem [WINDOW_DEPTH];
  logic        mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  wdata, rdata_q;

  logic [AW-1:0]         wp_q, wp_d, clr_q, clr_d;
  logic [COUNT_BITS-1:0] total_q, total_d, prod_q, prod_d, emit_q, emit_d;
  logic [COUNT_BITS-1:0] prod_put, emit_put;
  logic                  fin_q, fin_d, fin_eff;
  logic [63:0]           lane_q, lane_d, lane_put;
  logic [3:0]            lane_n_q, lane_n_d, n_put;
  logic [OFF_W-1:0]      off_q, off_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [RES_CNT_W-1:0]  rcnt_q, rcnt_d;

  logic        hold_v_q, hold_v_d;
  logic [63:0] hold_data_q, hold_data_d;
  logic [3:0]  hold_cnt_q, hold_cnt_d;
  logic [2:0]  hold_st_q, hold_st_d;

  logic        out_v_q, out_v_d, out_last_q, out_last_d;
  logic [63:0] out_data_q, out_data_d;
  logic [3:0]  out_cnt_q, out_cnt_d;
  logic [2:0]  out_st_q, out_st_d;

  logic        out_free, stall, pop, need_slot, emit_en, done_put, full_put;
  logic [7:0]  pb;
  logic        mk_v;
  logic [63:0] mk_data;
  logic [3:0]  mk_cnt;
  logic [2:0]  mk_st;

  assign out_free  = !out_v_q || out_ready_i;
  assign stall     = hold_v_q && !out_free;
  assign fin_eff   = cmd_i.start ? 1'b0 : fin_q;
  assign need_slot = (cmd_i.kind == CMD_STAT) || (cmd_i.kind == CMD_LIT && !fin_eff);
  assign pop       = (state_q == BK_IDLE) && cmd_valid_i && !(need_slot && stall);
  assign cmd_ready_o  = pop;
  assign clear_done_o = state_q != BK_CLEAR;

  // one decoded byte into window, counters and lane
  assign pb       = (state_q == BK_WRITE) ? rdata_q : cmd_i.data;
  assign emit_en  = CMP_W'(prod_q) >= CMP_W'(skip_count_i);
  assign prod_put = prod_q + COUNT_BITS'(1);
  assign emit_put = emit_q + COUNT_BITS'(emit_en);
  assign n_put    = lane_n_q + 4'(emit_en);
  assign done_put = (prod_put >= total_q) || (CMP_W'(emit_put) >= CMP_W'(emit_limit_i));
  assign full_put = n_put == 4'(LANE_BYTES);
  assign raddr    = wp_q - AW'(off_q) - AW'(1);

  always_comb begin
    lane_put = lane_q;
    if (emit_en) lane_put[{lane_n_q[2:0], 3'b000} +: 8] = pb;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (clr_q == AW'(WINDOW_DEPTH - 1)) state_d = BK_IDLE;
      BK_IDLE: begin
        if (pop) begin
          unique case (cmd_i.kind)
            CMD_STAT: state_d = BK_FLUSH;
            CMD_LIT:  state_d = fin_eff ? BK_IDLE : BK_FLUSH;
            CMD_COPY: state_d = fin_eff ? BK_IDLE : BK_READ;
            default:  state_d = BK_IDLE;
          endcase
        end
      end
      BK_READ:  state_d = BK_WRITE;
      BK_WRITE: begin
        if (!stall) state_d = (done_put || len_q == LEN_W'(1)) ? BK_FLUSH : BK_READ;
      end
      BK_FLUSH: begin
        if (lane_n_q == 4'd0 && !stall) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    wp_d = wp_q;  clr_d = clr_q;  total_d = total_q;  prod_d = prod_q;
    emit_d = emit_q;  fin_d = fin_q;  lane_d = lane_q;  lane_n_d = lane_n_q;
    off_d = off_q;  len_d = len_q;  rcnt_d = rcnt_q;
    hold_v_d = hold_v_q;  hold_data_d = hold_data_q;
    hold_cnt_d = hold_cnt_q;  hold_st_d = hold_st_q;
    out_v_d = out_v_q;  out_last_d = out_last_q;  out_data_d = out_data_q;
    out_cnt_d = out_cnt_q;  out_st_d = out_st_q;
    mem_we = 1'b0;  waddr = wp_q;  wdata = pb;
    mk_v = 1'b0;  mk_data = lane_put;  mk_cnt = n_put;  mk_st = ST_DATA;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    case (state_q)
      BK_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + AW'(1);
      end
      BK_IDLE: begin
        if (pop) begin
          if (cmd_i.start) begin
            wp_d = '0;  prod_d = '0;  emit_d = '0;  fin_d = 1'b0;
          end
          if (cmd_i.ld_size) total_d = COUNT_BITS'(cmd_i.size);
          case (cmd_i.kind)
            CMD_STAT: begin
              mk_v = 1'b1;  mk_data = '0;  mk_cnt = '0;  mk_st = cmd_i.status;
              if (cmd_i.stop) fin_d = 1'b1;
            end
            CMD_COPY: begin
              off_d = cmd_i.off;
              len_d = cmd_i.len;
            end
            default: ;
          endcase
        end
      end
      BK_FLUSH: begin
        if (lane_n_q != 4'd0) begin
          if (!stall) begin
            mk_v = 1'b1;  mk_data = lane_q;  mk_cnt = lane_n_q;
            lane_d = '0;  lane_n_d = '0;
          end
        end else if (!stall) begin
          if (hold_v_q) begin
            out_v_d = 1'b1;  out_last_d = 1'b1;  out_data_d = hold_data_q;
            out_cnt_d = hold_cnt_q;  out_st_d = hold_st_q;
            hold_v_d = 1'b0;
          end
          rcnt_d = '0;
        end
      end
      default: ;
    endcase

    // literal in idle or copied byte in write
    if ((pop && cmd_i.kind == CMD_LIT && !fin_eff) || (state_q == BK_WRITE && !stall)) begin
      mem_we   = 1'b1;
      wp_d     = wp_q + AW'(1);
      prod_d   = prod_put;
      emit_d   = emit_put;
      lane_d   = lane_put;
      lane_n_d = n_put;
      len_d    = len_q - LEN_W'(1);
      if (done_put) begin
        mk_v = 1'b1;  mk_st = ST_DONE;  fin_d = 1'b1;
        lane_d = '0;  lane_n_d = '0;
      end else if (full_put) begin
        mk_v = 1'b1;
        lane_d = '0;  lane_n_d = '0;
      end
    end

    // new result parks in hold; previous one leaves as not-last
    if (mk_v && rcnt_q < RES_CNT_W'(MAX_RESULTS)) begin
      if (hold_v_q) begin
        out_v_d = 1'b1;  out_last_d = 1'b0;  out_data_d = hold_data_q;
        out_cnt_d = hold_cnt_q;  out_st_d = hold_st_q;
      end
      hold_v_d = 1'b1;  hold_data_d = mk_data;  hold_cnt_d = mk_cnt;  hold_st_d = mk_st;
      rcnt_d = rcnt_q + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;  wp_q <= '0;  clr_q <= '0;  total_q <= '0;
      prod_q <= '0;  emit_q <= '0;  fin_q <= 1'b1;  lane_q <= '0;  lane_n_q <= '0;
      rcnt_q <= '0;  hold_v_q <= 1'b0;  out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;  wp_q <= wp_d;  clr_q <= clr_d;  total_q <= total_d;
      prod_q <= prod_d;  emit_q <= emit_d;  fin_q <= fin_d;  lane_q <= lane_d;
      lane_n_q <= lane_n_d;  rcnt_q <= rcnt_d;  hold_v_q <= hold_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;  len_q <= len_d;
    hold_data_q <= hold_data_d;  hold_cnt_q <= hold_cnt_d;  hold_st_q <= hold_st_d;
    out_last_q <= out_last_d;  out_data_q <= out_data_d;
    out_cnt_q <= out_cnt_d;  out_st_q <= out_st_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_bytes_o  = out_data_q;
  assign byte_count_o = out_cnt_q;
  assign run_last_o   = out_last_q;
  assign status_o     = out_st_q;

endmodule

// File: rtl/core/yaz0_stream_decompressor.sv
// Flow: the parser takes header and flag beats while the command FIFO has room;
//   the copy engine takes a literal and packs it, then hands off the lane; a
//   back-reference reads the window, then writes, for each copied byte and then
//   flushes the lane, as the read of the history window is registered. The copy
//   engine takes no new command until it is back in idle.
// Reset: clears control state, then sweeps the 4096-byte window to zero with
//   in_ready_o low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// yaz0_stream_decompressor
// Yaz0 byte-stream decoder with skip, emit limit and 8-byte lane packing.
// ----------------------------------------------------------------------------
module yaz0_stream_decompressor
  import yaz0_pkg::*;
#(
  parameter int LANE_BYTES   = 8,
  parameter int COUNT_BITS   = 24,
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // compressed input, one byte per beat
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 stream_start_i,
  // decoded output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          out_bytes_o,
  output logic [3:0]           byte_count_o,
  output logic                 run_last_o,
  output logic [2:0]           status_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  logic [REG_W-1:0] skip_q, limit_q;
  logic             clear_done;
  logic             f_valid, f_ready, b_valid, b_ready;
  cmd_t             f_cmd, b_cmd;

  // registers always writable; the user must write them only while the decoder is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= '0;
      limit_q <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SKIP:  skip_q  <= cfg_data_i;
        CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser: header, flags and codes -> at most one command per beat
  yaz0_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .stream_start_i,
    .skip_count_i (skip_q),
    .emit_limit_i (limit_q),
    .clear_done_i (clear_done),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd)
  );

  // decouples the parser from long copies
  yaz0_cmd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  // window, counting and packing
  yaz0_back #(
    .LANE_BYTES  (LANE_BYTES),
    .COUNT_BITS  (COUNT_BITS),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i  (b_valid),
    .cmd_ready_o  (b_ready),
    .cmd_i        (b_cmd),
    .skip_count_i (skip_q),
    .emit_limit_i (limit_q),
    .clear_done_o (clear_done),
    .out_valid_o,
    .out_ready_i,
    .out_bytes_o,
    .byte_count_o,
    .run_last_o,
    .status_o
  );

endmodule
